// File: rtl/aba_pkg.sv
// Shared types and constants for the arena bump allocator.
// Holds request modes, register indexes and the item, config and result structs.
// No dependencies.
`timescale 1ns / 1ps

package aba_pkg;

  localparam int unsigned FIELD_W   = 25;
  localparam int unsigned ALIGN_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FIELD_W-1:0] INIT_CAP_RESET = 25'd4096;

  typedef enum logic [2:0] {
    MODE_ALLOC         = 3'd0,
    MODE_ALIGNED_ALLOC = 3'd1,
    MODE_MARK          = 3'd2,
    MODE_ROLLBACK      = 3'd3,
    MODE_REINIT        = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROW_ENABLE        = 2'd0,
    CFG_ROUND_INITIAL_SIZE = 2'd1,
    CFG_INITIAL_CAPACITY   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [FIELD_W-1:0] request_size;
    logic [ALIGN_W-1:0] alignment_log2;
    logic [FIELD_W-1:0] rollback_offset;
  } item_t;

  typedef struct packed {
    logic               grow_enable;
    logic               round_initial_size;
    logic [FIELD_W-1:0] initial_capacity;
  } cfg_t;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] result_offset;
    logic [FIELD_W-1:0] capacity_now;
    logic               grew;
  } result_t;

endpackage

// File: rtl/aba_step.sv
// Single-request datapath of the arena bump allocator: padding, fit check,
// power-of-two growth and next state. Depends on aba_pkg.
`timescale 1ns / 1ps

module aba_step #(
  parameter int unsigned MAX_CAPACITY_LOG2 = 24,
  parameter int unsigned MAX_ALIGN_LOG2    = 12,
  parameter int unsigned CAP_W = (MAX_CAPACITY_LOG2 + 1 > 25) ? MAX_CAPACITY_LOG2 + 1 : 26
) (
  input  aba_pkg::item_t   item_i,
  input  aba_pkg::cfg_t    cfg_i,
  input  logic [CAP_W-1:0] used_i,
  input  logic [CAP_W-1:0] cap_i,
  output logic [CAP_W-1:0] used_o,
  output logic [CAP_W-1:0] cap_o,
  output aba_pkg::result_t result_o
);
  import aba_pkg::*;

  // two spare bits cover used + padding + request without wrap
  localparam int unsigned EW = CAP_W + 2;
  localparam logic [EW-1:0] CAP_LIMIT = EW'(1) << MAX_CAPACITY_LOG2;

  function automatic logic [EW-1:0] pow2_ceil(input logic [EW-1:0] x);
    logic [EW-1:0] v;
    v = x - EW'(1);
    for (int s = 1; s < int'(EW); s = s * 2) begin
      v = v | (v >> s);
    end
    if (x <= EW'(1)) begin
      pow2_ceil = EW'(1);
    end else begin
      pow2_ceil = v + EW'(1);
    end
  endfunction

  logic [EW-1:0] used_e, cap_e, amask, start, fin, grow_x, new_cap;
  logic [EW-1:0] init_raw, init_rnd, init_cap, mark_e;
  logic          align_ok, fits, grow_ok, alloc_ok;

  always_comb begin
    used_e   = EW'(used_i);
    cap_e    = EW'(cap_i);
    mark_e   = EW'(item_i.rollback_offset);
    align_ok = 32'(item_i.alignment_log2) <= 32'(MAX_ALIGN_LOG2);
    if (item_i.mode == MODE_ALIGNED_ALLOC && align_ok) begin
      amask = (EW'(1) << item_i.alignment_log2) - EW'(1);
    end else begin
      amask = '0;
    end
    start    = (used_e + amask) & ~amask;
    fin      = start + EW'(item_i.request_size);
    fits     = fin <= cap_e;
    grow_x   = cap_e + (fin - used_e);
    new_cap  = pow2_ceil(grow_x);
    grow_ok  = cfg_i.grow_enable && (grow_x <= CAP_LIMIT);
    alloc_ok = fits || grow_ok;

    // initial capacity: zero reads as one, optional rounding, saturate
    init_raw = (cfg_i.initial_capacity == '0) ? EW'(1) : EW'(cfg_i.initial_capacity);
    init_rnd = cfg_i.round_initial_size ? pow2_ceil(init_raw) : init_raw;
    init_cap = (init_rnd > CAP_LIMIT) ? CAP_LIMIT : init_rnd;
  end

  logic [CAP_W-1:0] used_d, cap_d;
  logic             ok_d, grew_d;
  logic [EW-1:0]    offset_d;

  always_comb begin
    used_d   = used_i;
    cap_d    = cap_i;
    ok_d     = 1'b0;
    grew_d   = 1'b0;
    offset_d = '0;
    unique case (item_i.mode)
      MODE_ALLOC, MODE_ALIGNED_ALLOC: begin
        if ((item_i.mode == MODE_ALLOC || align_ok) && alloc_ok) begin
          ok_d     = 1'b1;
          offset_d = start;
          used_d   = fin[CAP_W-1:0];
          if (!fits) begin
            cap_d  = new_cap[CAP_W-1:0];
            grew_d = 1'b1;
          end
        end
      end
      MODE_MARK: begin
        ok_d     = 1'b1;
        offset_d = used_e;
      end
      MODE_ROLLBACK: begin
        if (mark_e <= cap_e) begin
          ok_d   = 1'b1;
          used_d = mark_e[CAP_W-1:0];
        end
      end
      MODE_REINIT: begin
        ok_d   = 1'b1;
        used_d = '0;
        cap_d  = init_cap[CAP_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign used_o                 = used_d;
  assign cap_o                  = cap_d;
  assign result_o.ok            = ok_d;
  assign result_o.result_offset = offset_d[FIELD_W-1:0];
  assign result_o.capacity_now  = cap_d[FIELD_W-1:0];
  assign result_o.grew          = grew_d;

endmodule

// File: rtl/arena_bump_allocator.sv
// Arena bump allocator: a two-register request pipeline around aba_step.
// Depends on aba_pkg and aba_step.
//
// Usage
//   Requests arrive on the input channel (in_valid_i / in_stall_o) with mode,
//   request size, alignment and rollback offset. Each request gives exactly
//   one result transfer on the output channel (out_valid_o / out_stall_i):
//   ok, start offset or mark, capacity after the request, and a grew flag.
//   A result is registered: the request waits in the input register and the
//   allocation logic loads the result register from it, so the result
//   transfer follows the input transfer through both registers. Throughput
//   is one request per cycle while the receiver does not stall, set by the
//   single update of the used-offset and capacity registers that every
//   request makes.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more request, and after that in_stall_o rises.
//   The configuration port writes grow_enable, round_initial_size and
//   initial_capacity; write it only while no request is in flight. Initial
//   capacity settings take effect on a reinit request.
//   Reset empties both pipeline registers, clears the used offset and loads
//   the capacity from the reset initial capacity of 4096, saturated to
//   2**MAX_CAPACITY_LOG2.
`timescale 1ns / 1ps

module arena_bump_allocator #(
  parameter int unsigned MAX_CAPACITY_LOG2 = 24,
  parameter int unsigned MAX_ALIGN_LOG2    = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [aba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [aba_pkg::FIELD_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         mode_i,
  input  logic [aba_pkg::FIELD_W-1:0]        request_size_i,
  input  logic [aba_pkg::ALIGN_W-1:0]        alignment_log2_i,
  input  logic [aba_pkg::FIELD_W-1:0]        rollback_offset_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               ok_o,
  output logic [aba_pkg::FIELD_W-1:0]        result_offset_o,
  output logic [aba_pkg::FIELD_W-1:0]        capacity_now_o,
  output logic                               grew_o
);
  import aba_pkg::*;

  localparam int unsigned CAP_W =
    (MAX_CAPACITY_LOG2 + 1 > 25) ? MAX_CAPACITY_LOG2 + 1 : 26;
  localparam logic [63:0] LIMIT64 = 64'd1 << MAX_CAPACITY_LOG2;
  localparam logic [CAP_W-1:0] RESET_CAP =
    (64'(INIT_CAP_RESET) > LIMIT64) ? CAP_W'(LIMIT64) : CAP_W'(INIT_CAP_RESET);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grow_enable        <= 1'b0;
      cfg_q.round_initial_size <= 1'b0;
      cfg_q.initial_capacity   <= INIT_CAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GROW_ENABLE:        cfg_q.grow_enable        <= cfg_wdata_i[0];
        CFG_ROUND_INITIAL_SIZE: cfg_q.round_initial_size <= cfg_wdata_i[0];
        CFG_INITIAL_CAPACITY:   cfg_q.initial_capacity   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // pipeline control: result advances when empty or taken
  logic in_valid_q, out_valid_q;
  logic out_adv, in_take;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.mode            <= mode_i;
      item_q.request_size    <= request_size_i;
      item_q.alignment_log2  <= alignment_log2_i;
      item_q.rollback_offset <= rollback_offset_i;
    end
  end

  // allocator state and single-pass update
  logic [CAP_W-1:0] used_q, cap_q, used_d, cap_d;
  result_t          res_d, res_q;
  logic             step_fire;

  assign step_fire = in_valid_q && out_adv;

  aba_step #(
    .MAX_CAPACITY_LOG2 (MAX_CAPACITY_LOG2),
    .MAX_ALIGN_LOG2    (MAX_ALIGN_LOG2),
    .CAP_W             (CAP_W)
  ) u_step (
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .used_i   (used_q),
    .cap_i    (cap_q),
    .used_o   (used_d),
    .cap_o    (cap_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      cap_q       <= RESET_CAP;
      out_valid_q <= 1'b0;
    end else begin
      if (step_fire) begin
        used_q <= used_d;
        cap_q  <= cap_d;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // result register, holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = res_q.ok;
  assign result_offset_o = res_q.result_offset;
  assign capacity_now_o  = res_q.capacity_now;
  assign grew_o          = res_q.grew;

`ifndef NO_ASSERTIONS
  // offset never runs past the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= cap_q)
    else $error("used offset beyond capacity");

  // capacity stays within one and the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (64'(cap_q) <= LIMIT64))
    else $error("capacity out of range");

  // growth is only reported on a successful request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.grew |-> res_q.ok)
    else $error("grew without ok");

  // a held request is not dropped while the result side is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_adv |=> in_valid_q && out_valid_q)
    else $error("pending request lost under stall");
`endif

endmodule
